FILE: rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

    localparam int OPW        = 16;
    localparam int MW         = 2 * OPW + 1;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 30;
    localparam int SAT_W      = (MW > NUM_W + 1) ? MW : NUM_W + 1;
    localparam int IN_DATA_W  = ((4 * OPW + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;
    localparam int OP_W       = 2;
    localparam int CNT_W      = $clog2(MW);

    localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1) << (NUM_W - 1);
    localparam logic [SAT_W-1:0] POS_LIM = NEG_LIM - SAT_W'(1);
    localparam logic [SAT_W-1:0] DEN_LIM = (SAT_W'(1) << DEN_W) - SAT_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_REDUCE  = 2'd0,
        OP_INVERSE = 2'd1,
        OP_ADD     = 2'd2,
        OP_COMPARE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MUL_P = 2'd0,
        MUL_Q = 2'd1,
        MUL_D = 2'd2
    } t_mul_sel;

    typedef enum logic [1:0] {
        DV_GCD = 2'd0,
        DV_NUM = 2'd1,
        DV_DEN = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum;
        logic     cmp;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_num;
        logic     take_den;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic gb_zero;
    } t_sts;

endpackage

FILE: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Fraction unit: one request (operation in tuser, two signed fractions in tdata) gives one
// result beat. Reduce and add divide by the Euclidean gcd found with a bit-serial restoring
// divider, one modulo step at a time, before numerator and denominator are divided by it;
// inverse and compare use no divide. One request is in work at a time; the result register
// lets the next request enter while a result waits to be taken.
module rational_arithmetic_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // a_num, a_den, b_num, b_den
    input  logic [rau_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // req_type
    input  logic [rau_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // res_num, res_den, zero padding
    output logic [rau_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // zero_den_flag
    output logic [0:0]                        o_m_axis_tuser
);

    localparam int W = rau_pkg::OPW;

    rau_pkg::t_cmd             cmd;
    rau_pkg::t_sts             sts;
    rau_pkg::t_op              op;
    logic [rau_pkg::NUM_W-1:0] res_num;
    logic [rau_pkg::DEN_W-1:0] res_den;
    logic                      res_flag;

    assign op = rau_pkg::t_op'(i_s_axis_tuser);

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (op),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rau_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (op),
        .i_a_num    (i_s_axis_tdata[W-1:0]),
        .i_a_den    (i_s_axis_tdata[2*W-1:W]),
        .i_b_num    (i_s_axis_tdata[3*W-1:2*W]),
        .i_b_den    (i_s_axis_tdata[4*W-1:3*W]),
        .o_res_num  (res_num),
        .o_res_den  (res_den),
        .o_res_flag (res_flag)
    );

    assign o_m_axis_tdata = rau_pkg::OUT_DATA_W'({res_den, res_num});
    assign o_m_axis_tuser = res_flag;

endmodule

FILE: rtl/rau_div.sv
`timescale 1ns / 1ps
module rau_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rau_pkg::MW-1:0]  i_dividend,
    input  logic [rau_pkg::MW-1:0]  i_divisor,
    output logic                    o_done,
    output logic [rau_pkg::MW-1:0]  o_quot,
    output logic [rau_pkg::MW-1:0]  o_rem
);

    logic                      r_busy;
    logic                      r_done;
    logic [rau_pkg::CNT_W-1:0] r_cnt;
    logic [rau_pkg::MW-1:0]    r_q;
    logic [rau_pkg::MW-1:0]    r_rem;
    logic [rau_pkg::MW-1:0]    r_dvs;
    logic [rau_pkg::MW:0]      rem_sh;
    logic [rau_pkg::MW:0]      rem_nx;
    logic                      ge;

    always_comb begin
        rem_sh = {r_rem, r_q[rau_pkg::MW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + rau_pkg::CNT_W'(1);
                if (r_cnt == rau_pkg::CNT_W'(rau_pkg::MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[rau_pkg::MW-2:0], ge};
            r_rem <= rem_nx[rau_pkg::MW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/rau_datapath.sv
`timescale 1ns / 1ps
module rau_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rau_pkg::t_cmd              i_cmd,
    output rau_pkg::t_sts              o_sts,
    input  rau_pkg::t_op               i_op,
    input  logic [rau_pkg::OPW-1:0]    i_a_num,
    input  logic [rau_pkg::OPW-1:0]    i_a_den,
    input  logic [rau_pkg::OPW-1:0]    i_b_num,
    input  logic [rau_pkg::OPW-1:0]    i_b_den,
    output logic [rau_pkg::NUM_W-1:0]  o_res_num,
    output logic [rau_pkg::DEN_W-1:0]  o_res_den,
    output logic                       o_res_flag
);

    localparam int W  = rau_pkg::OPW;
    localparam int MW = rau_pkg::MW;
    localparam int SW = rau_pkg::SAT_W;

    function automatic logic [W-1:0] abs_op(input logic [W-1:0] v);
        return v[W-1] ? ((~v) + W'(1)) : v;
    endfunction

    logic [W-1:0]      an_mag, ad_abs, ad_mag, bn_mag, bd_abs, bd_mag, inv_den;
    logic              ad_zero, bd_zero, an_zero, a_neg, b_neg;
    logic [W-1:0]      mul_x, mul_y;
    logic [2*W-1:0]    prod;
    logic [MW-1:0]     pe, qe, sum_mag;
    logic              q_neg, sum_neg;
    logic [MW-1:0]     div_a, div_b, quot, rem;
    logic              div_done;
    logic [SW-1:0]     mag_w, den_w, mag_c, den_c;
    logic [rau_pkg::NUM_W-1:0] num_sat;

    logic              r_a_neg, r_b_neg, r_neg, r_flag;
    logic [W-1:0]      r_an, r_ad, r_bn, r_bd;
    logic [2*W-1:0]    r_p, r_q;
    logic [MW-1:0]     r_mag, r_den, r_ga, r_gb;
    logic [rau_pkg::NUM_W-1:0] r_res_num;
    logic [rau_pkg::DEN_W-1:0] r_res_den;
    logic              r_res_flag;

    always_comb begin
        an_mag  = abs_op(i_a_num);
        ad_abs  = abs_op(i_a_den);
        bn_mag  = abs_op(i_b_num);
        bd_abs  = abs_op(i_b_den);
        ad_zero = (i_a_den == '0);
        bd_zero = (i_b_den == '0);
        an_zero = (i_a_num == '0);
        ad_mag  = ad_zero ? W'(1) : ad_abs;
        bd_mag  = bd_zero ? W'(1) : bd_abs;
        inv_den = an_zero ? W'(1) : an_mag;
        a_neg   = !an_zero && (i_a_num[W-1] ^ i_a_den[W-1]);
        b_neg   = (i_b_num != '0) && (i_b_num[W-1] ^ i_b_den[W-1]);
    end

    always_comb begin
        case (i_cmd.mul_sel)
            rau_pkg::MUL_P: begin
                mul_x = r_an;
                mul_y = r_bd;
            end
            rau_pkg::MUL_Q: begin
                mul_x = r_bn;
                mul_y = r_ad;
            end
            default: begin
                mul_x = r_ad;
                mul_y = r_bd;
            end
        endcase
        prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
    end

    always_comb begin
        pe    = MW'(r_p);
        qe    = MW'(r_q);
        q_neg = r_b_neg ^ (i_cmd.cmp && (r_q != '0));
        if (r_a_neg == q_neg) begin
            sum_mag = pe + qe;
            sum_neg = r_a_neg;
        end else if (pe >= qe) begin
            sum_mag = pe - qe;
            sum_neg = r_a_neg;
        end else begin
            sum_mag = qe - pe;
            sum_neg = q_neg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            rau_pkg::DV_GCD: begin
                div_a = r_ga;
                div_b = r_gb;
            end
            rau_pkg::DV_NUM: begin
                div_a = r_mag;
                div_b = r_ga;
            end
            default: begin
                div_a = r_den;
                div_b = r_ga;
            end
        endcase
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an    <= an_mag;
            r_ad    <= ad_mag;
            r_bn    <= bn_mag;
            r_bd    <= bd_mag;
            r_a_neg <= a_neg;
            r_b_neg <= b_neg;
            r_neg   <= a_neg;
            r_flag  <= ad_zero
                       || ((i_op == rau_pkg::OP_ADD || i_op == rau_pkg::OP_COMPARE) && bd_zero)
                       || ((i_op == rau_pkg::OP_INVERSE) && an_zero);
            if (i_op == rau_pkg::OP_INVERSE) begin
                r_mag <= MW'(ad_mag);
                r_den <= MW'(inv_den);
            end else begin
                r_mag <= MW'(an_mag);
                r_den <= MW'(ad_mag);
            end
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rau_pkg::MUL_P: r_p   <= prod;
                rau_pkg::MUL_Q: r_q   <= prod;
                default:        r_den <= MW'(prod);
            endcase
        end
        if (i_cmd.sum) begin
            r_mag <= sum_mag;
            r_neg <= sum_neg;
            if (i_cmd.cmp) begin
                r_den <= MW'(1);
            end
        end
        if (i_cmd.gcd_init) begin
            r_ga <= r_mag;
            r_gb <= r_den;
        end
        if (i_cmd.gcd_step) begin
            r_ga <= r_gb;
            r_gb <= rem;
        end
        if (i_cmd.take_num) begin
            r_mag <= quot;
            if (quot == '0) begin
                r_neg <= 1'b0;
            end
        end
        if (i_cmd.take_den) begin
            r_den <= quot;
        end
        if (i_cmd.out_load) begin
            r_res_num  <= num_sat;
            r_res_den  <= den_c[rau_pkg::DEN_W-1:0];
            r_res_flag <= r_flag;
        end
    end

    always_comb begin
        mag_w = SW'(r_mag);
        den_w = SW'(r_den);
        if (r_neg) begin
            mag_c   = (mag_w > rau_pkg::NEG_LIM) ? rau_pkg::NEG_LIM : mag_w;
            num_sat = (~mag_c[rau_pkg::NUM_W-1:0]) + rau_pkg::NUM_W'(1);
        end else begin
            mag_c   = (mag_w > rau_pkg::POS_LIM) ? rau_pkg::POS_LIM : mag_w;
            num_sat = mag_c[rau_pkg::NUM_W-1:0];
        end
        if (den_w == '0) begin
            den_c = SW'(1);
        end else if (den_w > rau_pkg::DEN_LIM) begin
            den_c = rau_pkg::DEN_LIM;
        end else begin
            den_c = den_w;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.gb_zero  = (r_gb == '0);
    assign o_res_num      = r_res_num;
    assign o_res_den      = r_res_den;
    assign o_res_flag     = r_res_flag;

endmodule

FILE: rtl/rau_ctrl.sv
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rau_pkg::t_op  i_op,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output rau_pkg::t_cmd o_cmd,
    input  rau_pkg::t_sts i_sts
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MUL0 = 11'b00000000010,
        S_MUL1 = 11'b00000000100,
        S_MUL2 = 11'b00000001000,
        S_SUM  = 11'b00000010000,
        S_GINI = 11'b00000100000,
        S_GCHK = 11'b00001000000,
        S_GMOD = 11'b00010000000,
        S_QNUM = 11'b00100000000,
        S_QDEN = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state        r_state, n_state;
    rau_pkg::t_op  r_op, n_op;
    logic          r_out_valid, n_out_valid;
    rau_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_op     = i_op;
                    case (i_op)
                        rau_pkg::OP_REDUCE:  n_state = S_GINI;
                        rau_pkg::OP_INVERSE: n_state = S_OUT;
                        default:             n_state = S_MUL0;
                    endcase
                end
            end
            S_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MUL_P;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MUL_Q;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MUL_D;
                n_state     = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                cmd.cmp = (r_op == rau_pkg::OP_COMPARE);
                n_state = cmd.cmp ? S_OUT : S_GINI;
            end
            S_GINI: begin
                cmd.gcd_init = 1'b1;
                n_state      = S_GCHK;
            end
            S_GCHK: begin
                cmd.div_start = 1'b1;
                if (i_sts.gb_zero) begin
                    cmd.div_sel = rau_pkg::DV_NUM;
                    n_state     = S_QNUM;
                end else begin
                    cmd.div_sel = rau_pkg::DV_GCD;
                    n_state     = S_GMOD;
                end
            end
            S_GMOD: begin
                if (i_sts.div_done) begin
                    cmd.gcd_step = 1'b1;
                    n_state      = S_GCHK;
                end
            end
            S_QNUM: begin
                if (i_sts.div_done) begin
                    cmd.take_num  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rau_pkg::DV_DEN;
                    n_state       = S_QDEN;
                end
            end
            S_QDEN: begin
                if (i_sts.div_done) begin
                    cmd.take_den = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= rau_pkg::OP_REDUCE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

FILE: rtl/rau_checker.sv
`timescale 1ns / 1ps
module rau_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [rau_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                     o_m_axis_tuser
);

    localparam int DLO = rau_pkg::NUM_W;
    localparam int DHI = rau_pkg::NUM_W + rau_pkg::DEN_W - 1;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata)
                                                && $stable(o_m_axis_tuser))
        else $error("stalled result beat changed");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[DHI:DLO] != '0)
        else $error("result denominator is zero");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request taken while one is in work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;

    typedef struct {
        logic [31:0] num;
        logic [29:0] den;
        logic        flag;
    } t_frac_res;

    typedef struct {
        rau_pkg::t_op op;
        logic [15:0]  an;
        logic [15:0]  ad;
        logic [15:0]  bn;
        logic [15:0]  bd;
        logic         known;
        t_frac_res    res;
    } t_vec;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [rau_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [rau_pkg::OP_W-1:0]       i_s_axis_tuser;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [rau_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [0:0]                     o_m_axis_tuser;

    t_frac_res pending_q[$];
    t_vec      vecs[$];
    int        n_err;
    int        n_got;
    int        n_sent;
    bit        stim_done;

    rational_arithmetic_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_frac_res solve_frac(rau_pkg::t_op op, logic [15:0] an_r,
                                             logic [15:0] ad_r, logic [15:0] bn_r,
                                             logic [15:0] bd_r);
        longint an, ad, bn, bd, n, d, t;
        longint unsigned mag, den, g;
        logic flag;
        t_frac_res r;
        an = longint'($signed(an_r));
        ad = longint'($signed(ad_r));
        bn = longint'($signed(bn_r));
        bd = longint'($signed(bd_r));
        flag = 1'b0;
        if (ad == 0) begin ad = 1; flag = 1'b1; end
        if (ad < 0) begin an = -an; ad = -ad; end
        if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_COMPARE) begin
            if (bd == 0) begin bd = 1; flag = 1'b1; end
            if (bd < 0) begin bn = -bn; bd = -bd; end
        end
        case (op)
            rau_pkg::OP_REDUCE: begin n = an; d = ad; end
            rau_pkg::OP_INVERSE: begin
                n = ad; d = an;
                if (d == 0) begin d = 1; flag = 1'b1; end
                if (d < 0) begin n = -n; d = -d; end
            end
            rau_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            default: begin n = an * bd - bn * ad; d = 1; end
        endcase
        if (op == rau_pkg::OP_REDUCE || op == rau_pkg::OP_ADD) begin
            mag = (n < 0) ? longint'(-n) : n;
            g = euclid(mag, d);
            if (g != 0) begin
                t = longint'(g);
                n = n / t;
                d = d / t;
            end
        end
        if (n > 64'sh7FFFFFFF) n = 64'sh7FFFFFFF;
        if (n < -64'sh80000000) n = -64'sh80000000;
        if (d == 0) d = 1;
        if (d > 64'sh3FFFFFFF) d = 64'sh3FFFFFFF;
        r.num = n[31:0];
        r.den = d[29:0];
        r.flag = flag;
        return r;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1: return 16'sd32767;
            2: return -16'sd32767;
            3: return 16'h8000;
            4: return 16'($urandom_range(0, 16) - 8);
            5: return 16'($urandom_range(1, 12)) * 16'($urandom_range(1, 60));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_vec(rau_pkg::t_op op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd, logic known, logic [31:0] num,
                           logic [29:0] den, logic flag);
        t_vec v;
        v.op = op; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
        v.known = known;
        v.res.num = num; v.res.den = den; v.res.flag = flag;
        vecs.push_back(v);
    endtask

    task automatic send(t_vec v);
        t_frac_res r;
        r = v.known ? v.res : solve_frac(v.op, v.an, v.ad, v.bn, v.bd);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rau_pkg::IN_DATA_W'({v.bd, v.bn, v.ad, v.an});
        i_s_axis_tuser  <= v.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_q.push_back(r);
        n_sent++;
    endtask

    initial begin
        t_vec v;
        int burst, gap;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        n_err = 0; n_got = 0; n_sent = 0; stim_done = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_vec(rau_pkg::OP_REDUCE, 16'sd6, 16'sd4, 0, 0, 1, 32'sd3, 30'd2, 0);
        add_vec(rau_pkg::OP_REDUCE, 16'sd5, 16'sd0, 0, 16'sd0, 1, 32'sd5, 30'd1, 1);
        add_vec(rau_pkg::OP_REDUCE, 16'sd0, -16'sd7, 0, 0, 1, 32'sd0, 30'd1, 0);
        add_vec(rau_pkg::OP_REDUCE, 16'sd3, -16'sd9, 0, 0, 1, -32'sd1, 30'd3, 0);
        add_vec(rau_pkg::OP_REDUCE, 16'h8000, 16'sd2, 0, 0, 1, -32'sd16384, 30'd1, 0);
        add_vec(rau_pkg::OP_REDUCE, 16'sd32767, 16'sd32767, 0, 0, 1, 32'sd1, 30'd1, 0);
        add_vec(rau_pkg::OP_REDUCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 32'sd1, 30'd1,
                0);
        add_vec(rau_pkg::OP_INVERSE, 16'sd0, 16'sd5, 0, 0, 1, 32'sd5, 30'd1, 1);
        add_vec(rau_pkg::OP_INVERSE, -16'sd3, 16'sd4, 0, 0, 1, -32'sd4, 30'd3, 0);
        add_vec(rau_pkg::OP_INVERSE, 16'sd6, 16'sd4, 0, 16'sd0, 1, 32'sd4, 30'd6, 0);
        add_vec(rau_pkg::OP_INVERSE, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_vec(rau_pkg::OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1, 32'sd1, 30'd1, 0);
        add_vec(rau_pkg::OP_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2, 1, 32'sd0, 30'd1, 0);
        add_vec(rau_pkg::OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 1, 32'sd2, 30'd1, 1);
        add_vec(rau_pkg::OP_ADD, 16'sd32767, 16'sd32767, 16'sd1, 16'sd32766, 0, 0, 0, 0);
        add_vec(rau_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0, 0, 0, 0);
        add_vec(rau_pkg::OP_ADD, -16'sd32767, 16'sd1, -16'sd32767, 16'sd1, 1, -32'sd65534,
                30'd1, 0);
        add_vec(rau_pkg::OP_ADD, 16'sd1, 16'sd32767, 16'sd1, 16'sd32766, 0, 0, 0, 0);
        add_vec(rau_pkg::OP_COMPARE, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1, 32'sd1, 30'd1, 0);
        add_vec(rau_pkg::OP_COMPARE, 16'sd5, 16'sd0, 16'sd2, 16'sd0, 1, 32'sd3, 30'd1, 1);
        add_vec(rau_pkg::OP_COMPARE, 16'h8000, 16'h8000, 16'sd32767, -16'sd1, 0, 0, 0, 0);
        add_vec(rau_pkg::OP_COMPARE, 16'sd32767, 16'sd1, -16'sd32767, 16'sd32767, 0, 0, 0, 0);
        add_vec(rau_pkg::OP_COMPARE, 16'sd0, -16'sd5, 16'sd0, 16'sd7, 1, 32'sd0, 30'd1, 0);

        foreach (vecs[k]) begin
            @(negedge i_clk);
            send(vecs[k]);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end

        while (n_sent < 1250) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            repeat (burst) begin
                v.op = rau_pkg::t_op'($urandom_range(0, 3));
                v.an = rand_operand(); v.ad = rand_operand();
                v.bn = rand_operand(); v.bd = rand_operand();
                v.known = 1'b0;
                if (n_sent > 0) @(negedge i_clk);
                send(v);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        int mode;
        int cnt;
        i_m_axis_tready = 1'b0;
        mode = 0; cnt = 0;
        forever begin
            @(negedge i_clk);
            if (cnt == 0) begin
                mode = $urandom_range(0, 2);
                cnt = $urandom_range(20, 400);
            end
            cnt--;
            case (mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_frac_res e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_got++;
            if (pending_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected beat num=%0d den=%0d flag=%0b", $time,
                         $signed(o_m_axis_tdata[31:0]), o_m_axis_tdata[61:32],
                         o_m_axis_tuser[0]);
            end else begin
                e = pending_q.pop_front();
                if (o_m_axis_tdata[31:0] !== e.num) begin
                    n_err++;
                    $display("%0t: res_num expected %0d actual %0d", $time,
                             $signed(e.num), $signed(o_m_axis_tdata[31:0]));
                end
                if (o_m_axis_tdata[61:32] !== e.den) begin
                    n_err++;
                    $display("%0t: res_den expected %0d actual %0d", $time,
                             e.den, o_m_axis_tdata[61:32]);
                end
                if (o_m_axis_tuser[0] !== e.flag) begin
                    n_err++;
                    $display("%0t: zero_den_flag expected %0b actual %0b", $time,
                             e.flag, o_m_axis_tuser[0]);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (pending_q.size() != 0) n_err++;
        $display("covered %0d requests of all four operations, %0d results checked",
                 n_sent, n_got);
        if (n_err == 0) begin
            $display("rational_arithmetic_unit regression: pass");
        end else begin
            $display("rational_arithmetic_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("rational_arithmetic_unit regression: fail");
        $finish;
    end

endmodule
